[design/tsm_pkg.sv]
package tsm_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int NUM_STACKS  = 3;

  localparam int WORD_W  = 32;
  localparam int CAP_W   = 9;
  localparam int SN_W    = 2;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(256);
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = '0;

  typedef enum logic [1:0] {
    FN_PUSH = 2'd0,
    FN_POP  = 2'd1,
    FN_PEEK = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic accept;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_read;
  } dp_status_t;

  // First word of a stack's partition.
  function automatic logic [ADDR_W-1:0] stack_base(input logic [SN_W-1:0] sn);
    logic [ADDR_W-1:0] base;
    case (sn)
      2'd1:    base = ADDR_W'(STACK_DEPTH);
      2'd2:    base = ADDR_W'(2 * STACK_DEPTH);
      default: base = '0;
    endcase
    return base;
  endfunction

endpackage

[design/tsm_ram.sv]
module tsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

[design/tsm_ctrl.sv]
module tsm_ctrl
  import tsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && status.needs_read) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.accept  = 1'b0;
    cmd.capture = 1'b0;
    case (state_r)
      ST_IDLE: cmd.accept = start;
      ST_READ: begin
        busy        = 1'b1;
        cmd.capture = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

[design/tsm_datapath.sv]
module tsm_datapath
  import tsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          status,
  input  logic [1:0]          in_func,
  input  logic [SN_W-1:0]     in_stack_num,
  input  logic signed [31:0]  in_push_value,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                out_valid,
  output logic signed [31:0]  out_read_value,
  output logic                out_was_empty,
  output logic                out_push_dropped
);

  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [CNT_W-1:0]  cnt_r [NUM_STACKS];
  logic [CNT_W-1:0]  cnt_nxt [NUM_STACKS];
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] read_value_r, read_value_nxt;
  logic              was_empty_r, was_empty_nxt;
  logic              dropped_r, dropped_nxt;

  logic              cfg_wr;
  logic              sn_ok;
  logic [CNT_W-1:0]  cnt_sel;
  logic [CMP_W-1:0]  limit;
  logic              empty;
  logic              full;
  logic              is_push;
  logic              is_rd;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_rdata;

  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
  assign prdata = PDATA_W'(cap_r);

  assign sn_ok = (in_stack_num < SN_W'(NUM_STACKS));

  always_comb begin
    case (in_stack_num)
      2'd1:    cnt_sel = cnt_r[1];
      2'd2:    cnt_sel = cnt_r[2];
      default: cnt_sel = cnt_r[0];
    endcase
  end

  // Capacity beyond the partition saturates at the partition size.
  assign limit = (CMP_W'(cap_r) > CMP_W'(STACK_DEPTH)) ? CMP_W'(STACK_DEPTH)
                                                       : CMP_W'(cap_r);

  assign empty   = !sn_ok || (cnt_sel == '0);
  assign full    = !sn_ok || (CMP_W'(cnt_sel) >= limit);
  assign is_push = (in_func == FN_PUSH);
  assign is_rd   = (in_func == FN_POP) || (in_func == FN_PEEK);

  assign status.needs_read = is_rd && !empty;

  assign mem_we   = cmd.accept && is_push && !full;
  assign mem_addr = stack_base(in_stack_num)
                  + (is_push ? ADDR_W'(cnt_sel) : ADDR_W'(cnt_sel - CNT_W'(1)));

  tsm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(in_push_value),
    .rdata(mem_rdata)
  );

  always_comb begin
    cap_nxt = cap_r;
    for (int i = 0; i < NUM_STACKS; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (cfg_wr) begin
      cap_nxt = pwdata[CAP_W-1:0];
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_nxt[i] = '0;
      end
    end else if (cmd.accept && sn_ok) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        if (in_stack_num == SN_W'(i)) begin
          if (is_push && !full) begin
            cnt_nxt[i] = cnt_sel + CNT_W'(1);
          end else if ((in_func == FN_POP) && !empty) begin
            cnt_nxt[i] = cnt_sel - CNT_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt  = (cmd.accept && !status.needs_read) || cmd.capture;
    read_value_nxt = read_value_r;
    was_empty_nxt  = was_empty_r;
    dropped_nxt    = dropped_r;
    if (cmd.accept) begin
      was_empty_nxt  = empty;
      dropped_nxt    = is_push && full;
      read_value_nxt = (is_rd && empty) ? '1 : '0;
    end
    if (cmd.capture) begin
      read_value_nxt = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    read_value_r <= read_value_nxt;
    was_empty_r  <= was_empty_nxt;
    dropped_r    <= dropped_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = read_value_r;
  assign out_was_empty    = was_empty_r;
  assign out_push_dropped = dropped_r;

endmodule

[design/three_stacks_shared_memory.sv]
// Three LIFO stacks held in one shared memory, each in its own fixed
// partition of STACK_DEPTH words starting at stack_num * STACK_DEPTH.
// Input channel: an operation (push, pop, peek, or no-op) is transferred
// on a rising edge with start high and busy low.
// Result channel: exactly one result per operation, shown for one cycle
// with out_valid high; the receiver cannot hold it off.
// Result timing: push, no-op, and operations on an empty stack or on stack
// number three give their result in the cycle after the transfer, and a new
// operation may be transferred in that cycle. A pop or peek of a
// non-empty stack passes through the READ state while the registered read of
// the shared memory completes; busy is high in that state.
// Configuration: one APB register at byte address 0, stack_capacity
// (9 bits). Writing it empties all three stacks; write it only while idle.
// Reset: entry counts clear to zero and capacity becomes 256; the memory
// is not cleared, since only words below a stack's count are read.
module three_stacks_shared_memory
  import tsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [SN_W-1:0]    in_stack_num,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  output logic signed [31:0] out_read_value,
  output logic               out_was_empty,
  output logic               out_push_dropped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;

  tsm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  tsm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_func         (in_func),
    .in_stack_num    (in_stack_num),
    .in_push_value   (in_push_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_was_empty   (out_was_empty),
    .out_push_dropped(out_push_dropped)
  );

endmodule

[tb/three_stacks_shared_memory_tb.sv]
module three_stacks_shared_memory_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsm_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    func_t       func;
    logic [1:0]  sn;
    logic [31:0] value;
  } stack_cmd_t;

  typedef struct packed {
    logic [31:0] rd;
    logic        empty;
    logic        dropped;
  } stack_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_func;
  logic [SN_W-1:0]     in_stack_num;
  logic signed [31:0]  in_push_value;
  logic                out_valid;
  logic signed [31:0]  out_read_value;
  logic                out_was_empty;
  logic                out_push_dropped;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  three_stacks_shared_memory u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_stack_num     (in_stack_num),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_read_value   (out_read_value),
    .out_was_empty    (out_was_empty),
    .out_push_dropped (out_push_dropped),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Shadow copy of the stacks
  logic [31:0]       model_words [NUM_STACKS][STACK_DEPTH];
  logic [CNT_W-1:0]  model_count [NUM_STACKS];
  logic [CAP_W-1:0]  model_cap;

  stack_cmd_t    cmd_queue[$];
  stack_result_t want_results[$];

  int  errors;
  int  idle_cycles;
  bit  xfer_done;
  int  burst_left;
  int  gap_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Apply one operation to the shadow stacks and queue what the block must answer.
  task automatic predict_stack_op(input logic [1:0] f, input logic [1:0] sn,
                                  input logic [31:0] v);
    stack_result_t     r;
    logic [CMP_W-1:0]  lim;
    logic [CNT_W-1:0]  cnt;
    r.rd      = '0;
    r.empty   = 1'b1;
    r.dropped = 1'b0;
    lim = (CMP_W'(model_cap) > CMP_W'(STACK_DEPTH)) ? CMP_W'(STACK_DEPTH) : CMP_W'(model_cap);
    if (sn >= 2'(NUM_STACKS)) begin
      // nonexistent stack: always empty, no room
      if (f == FN_PUSH) begin
        r.dropped = 1'b1;
      end else if (f == FN_POP || f == FN_PEEK) begin
        r.rd = '1;
      end
    end else begin
      cnt = model_count[sn];
      r.empty = (cnt == '0);
      case (f)
        FN_PUSH: begin
          if (CMP_W'(cnt) >= lim) begin
            r.dropped = 1'b1;
          end else begin
            model_words[sn][cnt] = v;
            model_count[sn] = cnt + 1'b1;
          end
        end
        FN_POP, FN_PEEK: begin
          if (cnt == '0) begin
            r.rd = '1;
          end else begin
            r.rd = model_words[sn][cnt - 1'b1];
            if (f == FN_POP) model_count[sn] = cnt - 1'b1;
          end
        end
        default: ;
      endcase
    end
    want_results.push_back(r);
  endtask

  task automatic add_cmd(input func_t f, input logic [1:0] sn, input logic [31:0] v);
    stack_cmd_t c;
    c.func  = f;
    c.sn    = sn;
    c.value = v;
    cmd_queue.push_back(c);
  endtask

  task automatic add_random_cmds(input int n);
    int          r;
    func_t       f;
    logic [1:0]  sn;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      f = FN_PUSH;
      else if (r < 75) f = FN_POP;
      else if (r < 93) f = FN_PEEK;
      else             f = FN_NOP;
      sn = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = '1;
        3:       v = '0;
        default: v = $urandom;
      endcase
      add_cmd(f, sn, v);
    end
  endtask

  // Wait until every transfer went through and every result came back.
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || want_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= PDATA_W'(cap);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_cap = cap;
    for (int s = 0; s < NUM_STACKS; s++) model_count[s] = '0;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CAP_W-1:0] !== cap)
      report_mismatch($sformatf("capacity readback %0h, wrote %0h", prdata[CAP_W-1:0], cap));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: present queued operations in bursts with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || xfer_done) begin
      xfer_done = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        start         <= 1'b1;
        in_func       <= cmd_queue[0].func;
        in_stack_num  <= cmd_queue[0].sn;
        in_push_value <= cmd_queue[0].value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results first so a same-edge transfer cannot mask a stray result.
  always @(posedge clk) begin
    stack_result_t w;
    if (rst_n) begin
      idle_cycles++;
      if (out_valid) begin
        idle_cycles = 0;
        if (want_results.size() == 0) begin
          report_mismatch("result with no operation outstanding");
        end else begin
          w = want_results.pop_front();
          if (out_read_value !== w.rd)
            report_mismatch($sformatf("read_value %08h, want %08h", out_read_value, w.rd));
          if (out_was_empty !== w.empty)
            report_mismatch($sformatf("was_empty %b, want %b", out_was_empty, w.empty));
          if (out_push_dropped !== w.dropped)
            report_mismatch($sformatf("push_dropped %b, want %b", out_push_dropped, w.dropped));
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        predict_stack_op(in_func, in_stack_num, in_push_value);
        void'(cmd_queue.pop_front());
        xfer_done = 1'b1;
      end
      if (psel) idle_cycles = 0;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int wait_cnt;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = FN_NOP;
    in_stack_num  = '0;
    in_push_value = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    idle_cycles   = 0;
    xfer_done     = 1'b0;
    burst_left    = 1;
    gap_left      = 0;
    model_cap     = CAP_RESET;
    for (int s = 0; s < NUM_STACKS; s++) model_count[s] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset capacity: extremes of the word, empty stacks, stack three, no-op
    add_cmd(FN_PEEK, 2'd0, 32'h1111_1111);
    add_cmd(FN_POP,  2'd1, 32'h2222_2222);
    add_cmd(FN_PUSH, 2'd0, 32'h7FFF_FFFF);
    add_cmd(FN_PUSH, 2'd0, 32'h8000_0000);
    add_cmd(FN_PUSH, 2'd0, 32'hFFFF_FFFF);
    add_cmd(FN_PUSH, 2'd0, 32'h0000_0000);
    add_cmd(FN_PEEK, 2'd0, 32'h0);
    add_cmd(FN_POP,  2'd0, 32'h0);
    add_cmd(FN_POP,  2'd0, 32'h0);
    add_cmd(FN_POP,  2'd0, 32'h0);
    add_cmd(FN_PEEK, 2'd0, 32'h0);
    add_cmd(FN_POP,  2'd0, 32'h0);
    add_cmd(FN_POP,  2'd0, 32'h0);
    add_cmd(FN_PUSH, 2'd2, 32'h1234_5678);
    add_cmd(FN_PUSH, 2'd1, 32'hA5A5_A5A5);
    add_cmd(FN_NOP,  2'd2, 32'h0);
    add_cmd(FN_POP,  2'd2, 32'h0);
    add_cmd(FN_POP,  2'd1, 32'h0);
    add_cmd(FN_NOP,  2'd0, 32'h0);
    add_cmd(FN_PUSH, 2'd3, 32'hDEAD_BEEF);
    add_cmd(FN_POP,  2'd3, 32'h0);
    add_cmd(FN_PEEK, 2'd3, 32'h0);
    add_cmd(FN_NOP,  2'd3, 32'h0);
    wait_idle();

    // Capacity one: second push is refused
    program_capacity(9'd1);
    add_cmd(FN_PUSH, 2'd1, 32'h0F0F_0F0F);
    add_cmd(FN_PUSH, 2'd1, 32'hF0F0_F0F0);
    add_cmd(FN_PEEK, 2'd1, 32'h0);
    add_cmd(FN_POP,  2'd1, 32'h0);
    add_cmd(FN_POP,  2'd1, 32'h0);
    wait_idle();

    // Capacity zero: always full and empty
    program_capacity(9'd0);
    add_cmd(FN_PUSH, 2'd0, 32'h5555_5555);
    add_cmd(FN_POP,  2'd0, 32'h0);
    add_cmd(FN_PEEK, 2'd2, 32'h0);
    add_cmd(FN_NOP,  2'd1, 32'h0);
    wait_idle();

    // Capacity above the partition size saturates: fill stack one past the top
    program_capacity(9'h1FF);
    for (int i = 0; i < STACK_DEPTH + 2; i++) add_cmd(FN_PUSH, 2'd1, $urandom);
    add_cmd(FN_PEEK, 2'd1, 32'h0);
    for (int i = 0; i < 4; i++) add_cmd(FN_POP, 2'd1, 32'h0);
    wait_idle();

    // Random traffic under several capacities; each write also clears the leftovers
    program_capacity(9'd3);
    add_random_cmds(40);
    wait_idle();
    program_capacity(9'd256);
    add_random_cmds(40);
    wait_idle();
    program_capacity(9'd2);
    add_random_cmds(40);
    wait_idle();
    program_capacity(CAP_W'($urandom_range(4, 16)));
    add_random_cmds(40);

    while (cmd_queue.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (want_results.size() != 0 && wait_cnt < 20) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (4) @(posedge clk);
    if (want_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", want_results.size()));
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
